// ----- rtl/fec_pkg.sv -----
// ----------------------------------------------------------------------------
// fec_pkg: shared types and constants of the FAT entry cache.
// Holds the command and outcome codes, the request struct and the result struct.
// ----------------------------------------------------------------------------
package fec_pkg;

    localparam int CLUSTER_W = 28;
    localparam int VALUE_W   = 32;
    localparam int SECTOR_W  = 32;
    localparam int OFFSET_W  = 12;
    localparam int RSC_W     = 16;
    localparam int SHIFT_W   = 4;

    localparam logic [0:0] CMD_LOOKUP = 1'b0;
    localparam logic [0:0] CMD_FILL   = 1'b1;

    localparam logic [1:0] OUT_HIT  = 2'd0;
    localparam logic [1:0] OUT_MISS = 2'd1;
    localparam logic [1:0] OUT_FILL = 2'd2;

    localparam logic [0:0] REG_RSC   = 1'b0;
    localparam logic [0:0] REG_SHIFT = 1'b1;

    localparam logic [SHIFT_W-1:0] SHIFT_MIN = 4'd9;
    localparam logic [SHIFT_W-1:0] SHIFT_MAX = 4'd12;

    // Work item as classified by the front end.
    typedef struct packed {
        logic [0:0]           cmd;
        logic [CLUSTER_W-1:0] cluster;
        logic [VALUE_W-1:0]   value;
        logic [SECTOR_W-1:0]  sector;
        logic [OFFSET_W-1:0]  offset;
    } req_t;

    // Result beat handed to the output queue.
    typedef struct packed {
        logic [1:0]          outcome;
        logic [VALUE_W-1:0]  value;
        logic [SECTOR_W-1:0] sector;
        logic [OFFSET_W-1:0] offset;
    } rsp_t;

endpackage

// ----- rtl/fec_front.sv -----
// ----------------------------------------------------------------------------
// fec_front: input stage of the FAT entry cache.
// Registers an accepted item and precomputes the miss sector and offset.
// ----------------------------------------------------------------------------
module fec_front
    import fec_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push,
    output logic                 full,
    input  logic [0:0]           cmd,
    input  logic [CLUSTER_W-1:0] cluster_number,
    input  logic [VALUE_W-1:0]   fill_value,
    input  logic [RSC_W-1:0]     rsc,
    input  logic [SHIFT_W-1:0]   shift,
    output logic                 req_valid,
    input  logic                 req_ready,
    output req_t                 req
);

    logic                  valid_reg;
    req_t                  req_reg;
    req_t                  req_next;
    logic [SHIFT_W-1:0]    sh;
    logic [CLUSTER_W+1:0]  bytes;
    logic [CLUSTER_W+1:0]  shifted;
    logic [OFFSET_W-1:0]   mask;

    always_comb
    begin
        sh = shift;
        if (sh < SHIFT_MIN)
        begin
            sh = SHIFT_MIN;
        end
        if (sh > SHIFT_MAX)
        begin
            sh = SHIFT_MAX;
        end
        bytes   = {cluster_number, 2'b00};
        shifted = bytes >> sh;
        mask    = OFFSET_W'((13'd1 << sh) - 13'd1);
        req_next.cmd     = cmd;
        req_next.cluster = cluster_number;
        req_next.value   = fill_value;
        req_next.sector  = SECTOR_W'(rsc) + SECTOR_W'(shifted);
        req_next.offset  = bytes[OFFSET_W-1:0] & mask;
    end

    assign full      = valid_reg && !req_ready;
    assign req_valid = valid_reg;
    assign req       = req_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (!full)
        begin
            valid_reg <= push;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push && !full)
        begin
            req_reg <= req_next;
        end
    end

endmodule

// ----- rtl/fec_back.sv -----
// ----------------------------------------------------------------------------
// fec_back: set storage and move-to-front update of the FAT entry cache.
// Registers one set on accept; compares and on a fill or hit writes it back.
// ----------------------------------------------------------------------------
module fec_back
    import fec_pkg::*;
#(
    parameter int SET_COUNT = 16,
    parameter int WAY_COUNT = 4
)
(
    input  logic clk,
    input  logic rst_n,
    input  logic req_valid,
    output logic req_ready,
    input  req_t req,
    output logic rsp_valid,
    input  logic rsp_ready,
    output rsp_t rsp
);

    localparam int SET_W = (SET_COUNT > 1) ? $clog2(SET_COUNT) : 1;
    localparam int WAY_W = (WAY_COUNT > 1) ? $clog2(WAY_COUNT) : 1;

    typedef struct packed {
        logic [CLUSTER_W-1:0] cluster;
        logic [VALUE_W-1:0]   value;
    } way_t;

    way_t mem_reg [SET_COUNT][WAY_COUNT];
    logic [WAY_COUNT-1:0] valid_reg [SET_COUNT];

    logic       busy_reg;
    req_t       cur_reg;
    logic [SET_W-1:0] set_reg;
    way_t       rd_reg [WAY_COUNT];
    logic [WAY_COUNT-1:0] rdv_reg;
    logic       out_valid_reg;
    rsp_t       out_reg;

    logic [SET_W-1:0] set_in;
    logic       hit;
    logic [WAY_W-1:0] hit_way;
    logic [WAY_W-1:0] pos;
    logic [VALUE_W-1:0] front_val;
    way_t       wr [WAY_COUNT];
    logic [WAY_COUNT-1:0] wrv;
    rsp_t       rsp_next;
    logic       finish;

    // Set = low cluster bits; user keeps SET_COUNT a power of 2, unchecked.
    assign set_in = (SET_COUNT > 1) ? req.cluster[SET_W-1:0] : '0;
    assign finish = busy_reg && (!out_valid_reg || rsp_ready);
    assign req_ready = !busy_reg;
    assign rsp_valid = out_valid_reg;
    assign rsp       = out_reg;

    always_comb
    begin
        hit     = 1'b0;
        hit_way = '0;
        for (int w = WAY_COUNT - 1; w >= 0; w--)
        begin
            if (rdv_reg[w] && rd_reg[w].cluster == cur_reg.cluster)
            begin
                hit     = 1'b1;
                hit_way = WAY_W'(w);
            end
        end
        pos = hit ? hit_way : WAY_W'(WAY_COUNT - 1);
        front_val = (cur_reg.cmd == CMD_FILL) ? cur_reg.value : rd_reg[hit_way].value;
        for (int w = 0; w < WAY_COUNT; w++)
        begin
            if (w == 0)
            begin
                wr[w]  = '{cluster: cur_reg.cluster, value: front_val};
                wrv[w] = 1'b1;
            end
            else if (WAY_W'(w) <= pos)
            begin
                wr[w]  = rd_reg[w-1];
                wrv[w] = rdv_reg[w-1];
            end
            else
            begin
                wr[w]  = rd_reg[w];
                wrv[w] = rdv_reg[w];
            end
        end
        rsp_next = '0;
        if (cur_reg.cmd == CMD_FILL)
        begin
            rsp_next.outcome = OUT_FILL;
            rsp_next.value   = cur_reg.value;
        end
        else if (hit)
        begin
            rsp_next.outcome = OUT_HIT;
            rsp_next.value   = front_val;
        end
        else
        begin
            rsp_next.outcome = OUT_MISS;
            rsp_next.sector  = cur_reg.sector;
            rsp_next.offset  = cur_reg.offset;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
            for (int s = 0; s < SET_COUNT; s++)
            begin
                valid_reg[s] <= '0;
            end
        end
        else
        begin
            if (req_valid && !busy_reg)
            begin
                busy_reg <= 1'b1;
            end
            else if (finish)
            begin
                busy_reg <= 1'b0;
            end
            if (finish)
            begin
                out_valid_reg <= 1'b1;
                if (cur_reg.cmd == CMD_FILL || hit)
                begin
                    valid_reg[set_reg] <= wrv;
                end
            end
            else if (rsp_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req_valid && !busy_reg)
        begin
            cur_reg <= req;
            set_reg <= set_in;
            rdv_reg <= valid_reg[set_in];
            for (int w = 0; w < WAY_COUNT; w++)
            begin
                rd_reg[w] <= mem_reg[set_in][w];
            end
        end
        if (finish)
        begin
            out_reg <= rsp_next;
            if (cur_reg.cmd == CMD_FILL || hit)
            begin
                for (int w = 0; w < WAY_COUNT; w++)
                begin
                    mem_reg[set_reg][w] <= wr[w];
                end
            end
        end
    end

endmodule

// ----- rtl/fat_entry_set_assoc_mru_cache_unit.sv -----
// ----------------------------------------------------------------------------
// fat_entry_set_assoc_mru_cache_unit: FAT32 table entry cache.
// Set associative, move-to-front replacement, with miss address generation.
// ----------------------------------------------------------------------------
// Usage: write reserved_sector_count (index 0) and sector_size_shift (index 1)
// through the configuration channel while the block is idle. Items enter with
// push when full is low; a lookup (cmd 0) returns a hit with the cached value
// or a miss with the sector and byte offset to read, and a fill (cmd 1) stores
// the value at the front of its set. Each item yields exactly one result beat,
// taken with pop while empty is low.
// An accepted item passes the input register, then the set read registers of
// the back end, and its result is loaded into the result register together
// with the compare and write back. The back end takes no new item until the
// current one is finished; the input register can take one item meanwhile.
// Reset clears all way valid bits at once and loads the register defaults.
// When pop stays low the result register holds, the back end stalls, and full
// rises once the input register is also occupied.
// ----------------------------------------------------------------------------
module fat_entry_set_assoc_mru_cache_unit
    import fec_pkg::*;
#(
    parameter int SET_COUNT = 16,
    parameter int WAY_COUNT = 4
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push,
    output logic                 full,
    input  logic [0:0]           cmd,
    input  logic [CLUSTER_W-1:0] cluster_number,
    input  logic [VALUE_W-1:0]   fill_value,
    output logic                 empty,
    input  logic                 pop,
    output logic [1:0]           outcome,
    output logic [VALUE_W-1:0]   entry_value,
    output logic [SECTOR_W-1:0]  fetch_sector,
    output logic [OFFSET_W-1:0]  fetch_byte_offset,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [0:0]           cfg_index,
    input  logic [31:0]          cfg_data
);

    logic [RSC_W-1:0]   rsc_reg;
    logic [SHIFT_W-1:0] shift_reg;
    logic               req_valid;
    logic               req_ready;
    req_t               req;
    logic               rsp_valid;
    rsp_t               rsp;

    // Configuration writes are always taken.
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsc_reg   <= 16'd32;
            shift_reg <= 4'd9;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                REG_RSC:   rsc_reg   <= cfg_data[RSC_W-1:0];
                REG_SHIFT: shift_reg <= cfg_data[SHIFT_W-1:0];
                default:   ;
            endcase
        end
    end

    fec_front u_front (
        .clk            (clk),
        .rst_n          (rst_n),
        .push           (push),
        .full           (full),
        .cmd            (cmd),
        .cluster_number (cluster_number),
        .fill_value     (fill_value),
        .rsc            (rsc_reg),
        .shift          (shift_reg),
        .req_valid      (req_valid),
        .req_ready      (req_ready),
        .req            (req)
    );

    fec_back #(
        .SET_COUNT (SET_COUNT),
        .WAY_COUNT (WAY_COUNT)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_ready (pop),
        .rsp       (rsp)
    );

    assign empty             = !rsp_valid;
    assign outcome           = rsp.outcome;
    assign entry_value       = rsp.value;
    assign fetch_sector      = rsp.sector;
    assign fetch_byte_offset = rsp.offset;

endmodule

// ----- rtl/fec_checker.sv -----
// ----------------------------------------------------------------------------
// fec_checker: port level checks of the FAT entry cache.
// Watches result encoding and queue behavior on the top level ports.
// ----------------------------------------------------------------------------
module fec_checker
    import fec_pkg::*;
(
    input logic                clk,
    input logic                rst_n,
    input logic                empty,
    input logic                pop,
    input logic [1:0]          outcome,
    input logic [VALUE_W-1:0]  entry_value,
    input logic [SECTOR_W-1:0] fetch_sector,
    input logic [OFFSET_W-1:0] fetch_byte_offset
);

    a_no_bad_outcome: assert property (@(posedge clk) disable iff (!rst_n)
        !empty |-> (outcome == OUT_HIT || outcome == OUT_MISS || outcome == OUT_FILL))
        else $error("illegal outcome code");

    a_miss_zero_value: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && outcome == OUT_MISS) |-> entry_value == '0)
        else $error("miss carries a value");

    a_hit_zero_addr: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && outcome != OUT_MISS) |-> (fetch_sector == '0 && fetch_byte_offset == '0))
        else $error("fetch address on non-miss");

    a_result_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !pop) |=> (!empty && $stable(outcome) && $stable(entry_value)))
        else $error("stalled result changed");

endmodule

bind fat_entry_set_assoc_mru_cache_unit fec_checker u_fec_checker (
    .clk               (clk),
    .rst_n             (rst_n),
    .empty             (empty),
    .pop               (pop),
    .outcome           (outcome),
    .entry_value       (entry_value),
    .fetch_sector      (fetch_sector),
    .fetch_byte_offset (fetch_byte_offset)
);
